// ===== sv/jse_pkg.sv =====
// types, constants and helpers shared by the json string escape blocks
package jse_pkg;

  localparam logic [7:0] QUOTE      = 8'h22;
  localparam logic [7:0] BSLASH     = 8'h5c;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_N     = 8'h6e;
  localparam logic [7:0] CHAR_R     = 8'h72;
  localparam logic [7:0] CHAR_T     = 8'h74;
  localparam logic [7:0] CHAR_U     = 8'h75;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CTRL_LIMIT = 8'h20;

  typedef logic [2:0] step_t;

  localparam step_t STEP_OPEN  = 3'd0;
  localparam step_t STEP_BODY  = 3'd1;
  localparam step_t STEP_CLOSE = 3'd7;

  typedef enum logic [1:0] {
    CLS_EMPTY,
    CLS_PLAIN,
    CLS_PAIR,
    CLS_UNI
  } cls_t;

  typedef struct packed {
    cls_t       cls;
    logic [7:0] ch;
    logic       first;
    logic       last;
  } desc_t;

  function automatic step_t body_len(input cls_t cls);
    step_t len;
    unique case (cls)
      CLS_EMPTY: len = 3'd0;
      CLS_PLAIN: len = 3'd1;
      CLS_PAIR:  len = 3'd2;
      CLS_UNI:   len = 3'd6;
      default:   len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'd0, nib};
    end else begin
      c = 8'h57 + {4'd0, nib};
    end
    return c;
  endfunction

endpackage

// ===== sv/jse_front.sv =====
// front end: accepts source bytes and classifies the escape each one needs
module jse_front (
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          kind,
  input  logic [7:0]    text_byte,
  input  logic          starts_text,
  input  logic          ends_text,
  input  logic          q_full,
  output logic          push,
  output jse_pkg::desc_t desc
);
  import jse_pkg::*;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    desc.first = starts_text;
    desc.last  = ends_text;
    desc.ch    = text_byte;
    desc.cls   = CLS_PLAIN;
    if (kind) begin
      desc.cls   = CLS_EMPTY;
      desc.first = 1'b1;
      desc.last  = 1'b1;
    end else begin
      unique case (text_byte) inside
        QUOTE, BSLASH: desc.cls = CLS_PAIR;
        CHAR_LF: begin
          desc.cls = CLS_PAIR;
          desc.ch  = CHAR_N;
        end
        CHAR_CR: begin
          desc.cls = CLS_PAIR;
          desc.ch  = CHAR_R;
        end
        CHAR_TAB: begin
          desc.cls = CLS_PAIR;
          desc.ch  = CHAR_T;
        end
        default: begin
          if (text_byte < CTRL_LIMIT) begin
            desc.cls = CLS_UNI;
          end
        end
      endcase
    end
  end

endmodule

// ===== sv/jse_queue.sv =====
// small fifo of classified items between front and back
module jse_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  jse_pkg::desc_t push_data,
  input  logic           pop,
  output logic           full,
  output logic           head_valid,
  output jse_pkg::desc_t head
);
  import jse_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  desc_t         mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == FULL_CNT);
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/jse_back.sv =====
// back end: expands each classified item into output bytes, one per cycle while out_ready is high
module jse_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  jse_pkg::desc_t head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic           last_of_run,
  output logic           text_done
);
  import jse_pkg::*;

  logic       mid;
  logic       mid_next;
  step_t      step;
  step_t      step_next;
  step_t      cur;
  step_t      len;
  logic       load;
  logic       final_step;
  logic [7:0] byte_next;

  assign load = head_valid && (!out_valid || out_ready);
  assign len  = body_len(head.cls);
  assign cur  = mid ? step : (head.first ? STEP_OPEN : STEP_BODY);
  assign pop  = load && final_step;

  always_comb begin
    final_step = 1'b0;
    step_next  = cur;
    if (cur == STEP_CLOSE) begin
      final_step = 1'b1;
    end else if (cur == STEP_OPEN) begin
      step_next  = (len == '0) ? STEP_CLOSE : STEP_BODY;
    end else if (cur == len) begin
      final_step = !head.last;
      step_next  = STEP_CLOSE;
    end else begin
      step_next  = cur + 1'b1;
    end
  end

  always_comb begin
    byte_next = QUOTE;
    if (cur != STEP_OPEN && cur != STEP_CLOSE) begin
      case (head.cls)
        CLS_PLAIN: byte_next = head.ch;
        CLS_PAIR:  byte_next = (cur == STEP_BODY) ? BSLASH : head.ch;
        CLS_UNI: begin
          case (cur)
            3'd1:    byte_next = BSLASH;
            3'd2:    byte_next = CHAR_U;
            3'd5:    byte_next = hex_char(head.ch[7:4]);
            3'd6:    byte_next = hex_char(head.ch[3:0]);
            default: byte_next = CHAR_ZERO;
          endcase
        end
        default:   byte_next = QUOTE;
      endcase
    end
  end

  assign mid_next = load ? !final_step : mid;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      mid <= mid_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      step        <= step_next;
      out_byte    <= byte_next;
      last_of_run <= final_step;
      text_done   <= (cur == STEP_CLOSE);
    end
  end

endmodule

// ===== sv/json_string_escape_latin1.sv =====
// top level of the latin-1 to quoted json string escaper
// Takes one Latin-1 byte per item, marked first and/or last of its string, and gives out
// the quoted, escaped JSON text one byte per result item. A plain byte gives one output
// byte, the first and last items of a string each add a quote byte, a two-character escape
// gives two bytes and a \u00xx escape six; the output byte register emits one byte per cycle
// while out_ready is high and an item waits. The classifier accepts items ahead of the
// expander through a DEPTH-entry queue, so a byte is accepted every cycle while it has room.
module json_string_escape_latin1 #(
  parameter int DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       kind,
  input  logic [7:0] text_byte,
  input  logic       starts_text,
  input  logic       ends_text,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       last_of_run,
  output logic       text_done
);
  import jse_pkg::*;

  logic  push;
  logic  pop;
  logic  q_full;
  logic  head_valid;
  desc_t desc;
  desc_t head;

  jse_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .text_byte   (text_byte),
    .starts_text (starts_text),
    .ends_text   (ends_text),
    .q_full      (q_full),
    .push        (push),
    .desc        (desc)
  );

  jse_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (desc),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  jse_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .text_done   (text_done)
  );

endmodule

// ===== sv/jse_checker.sv =====
// port-level checks for the json string escaper and their bind
module jse_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       last_of_run,
  input logic       text_done
);
  import jse_pkg::*;

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last_of_run)
      && $stable(text_done))
    else $error("stalled output item changed");

  a_done_quote: assert property (@(posedge clk) disable iff (rst)
    out_valid && text_done |-> out_byte == QUOTE)
    else $error("string end on a byte other than a quote");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && text_done |-> last_of_run)
    else $error("closing quote not the final byte of its item");

endmodule

bind json_string_escape_latin1 jse_checker u_jse_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_byte    (out_byte),
  .last_of_run (last_of_run),
  .text_done   (text_done)
);
